// ===== design/tket_pkg.sv =====
package tket_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int INDEX_BITS = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEEP_W     = 5;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

  typedef enum logic {
    REG_KEEP_COUNT = 1'b0,
    REG_MAG_RANK   = 1'b1
  } reg_sel_e;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } state_e;

  typedef struct packed {
    op_e                           operation;
    logic [INDEX_BITS-1:0]         elem_row;
    logic [INDEX_BITS-1:0]         elem_col;
    logic signed [VALUE_BITS-1:0]  elem_value;
  } in_item_t;

  typedef struct packed {
    logic                          out_valid;
    logic [INDEX_BITS-1:0]         out_row;
    logic [INDEX_BITS-1:0]         out_col;
    logic signed [VALUE_BITS-1:0]  out_value;
    logic                          out_last;
  } out_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]         row;
    logic [INDEX_BITS-1:0]         col;
    logic signed [VALUE_BITS-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
    logic active;
    logic write;
    logic mag_rank;
  } cell_ctrl_t;

  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MAX_POS  = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Unsigned key whose order matches the ranking order of the value.
  function automatic logic [VALUE_BITS-1:0] key_of(logic [VALUE_BITS-1:0] v,
                                                   logic abs_m);
    logic [VALUE_BITS-1:0] k;
    if (!abs_m) begin
      k = v ^ SIGN_BIT;
    end else if (!v[VALUE_BITS-1]) begin
      k = v;
    end else if (v == SIGN_BIT) begin
      k = MAX_POS;
    end else begin
      k = (~v) + VALUE_BITS'(1);
    end
    return k;
  endfunction

endpackage

// ===== design/tket_cell.sv =====
module tket_cell (
  input  logic                                clk_i,
  input  tket_pkg::cell_ctrl_t                ctrl_i,
  input  tket_pkg::entry_t                    new_entry_i,
  input  logic [tket_pkg::VALUE_BITS-1:0]     new_key_i,
  input  tket_pkg::entry_t                    left_i,
  input  tket_pkg::entry_t                    right_i,
  input  logic                                found_i,
  output logic                                found_o,
  output tket_pkg::entry_t                    entry_o
);
  import tket_pkg::*;

  entry_t                entry_q;
  entry_t                entry_d;
  logic [VALUE_BITS-1:0] own_key;
  logic                  greater;
  logic                  take_new;
  logic                  take_left;

  always_comb begin
    own_key   = key_of(entry_q.value, ctrl_i.mag_rank);
    greater   = own_key > new_key_i;
    found_o   = found_i | (ctrl_i.active & ~greater);
    take_new  = ctrl_i.insert & ctrl_i.write & ~found_i & (~ctrl_i.active | ~greater);
    take_left = ctrl_i.insert & ctrl_i.write & found_i;
    entry_d   = entry_q;
    priority if (ctrl_i.shift_out) begin
      entry_d = right_i;
    end else if (take_new) begin
      entry_d = new_entry_i;
    end else if (take_left) begin
      entry_d = left_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== design/top_k_element_tracker.sv =====
// Top-k element tracker.
// Items enter on item_i, accepted at a rising edge with start_i high and busy_o low.
// An offer produces no result; a new offer may follow in every cycle while busy_o
// is low. The list lives in a row of cells; each cell compares its
// own key with the new key in parallel and the insert point ripples down the row.
// A flush with n held entries raises busy_o while the row shifts toward the head;
// result_o carries one entry per cycle with strobe_o high, the first once the state
// register has entered ST_FLUSH and the result register has taken the head entry,
// the final one marked by out_last. A flush of an empty list gives one result with
// out_valid low in the cycle right after acceptance and does not raise busy_o. The
// receiver cannot stall: every result stands on result_o for exactly one cycle.
// Throughput is one offer per cycle while busy_o is low; after a flush the next beat
// is taken once busy_o has fallen.
// keep_count sits at byte address 0 and the magnitude-ranking flag at byte
// address 4 of the APB port; the user must write them only while the block is idle,
// which the block itself does not enforce. Reset empties the list, sets keep_count
// to 10 and clears the ranking flag; cell contents are not reset.
module top_k_element_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tket_pkg::in_item_t            item_i,
  output logic                          strobe_o,
  output tket_pkg::out_item_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tket_pkg::APB_AW-1:0]   paddr,
  input  logic [tket_pkg::APB_DW-1:0]   pwdata,
  output logic [tket_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tket_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [KEEP_W-1:0]  keep_q;
  logic               abs_q;
  logic               strobe_q, strobe_d;
  out_item_t          result_q, result_d;

  logic               accept;
  logic               do_offer;
  logic               do_flush;
  logic               cfg_wr;
  reg_sel_e           reg_sel;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   newfill;
  logic [CNT_W:0]     fill_inc;
  logic [VALUE_BITS-1:0] new_key;
  entry_t             new_entry;

  entry_t             ent   [MAX_KEEP];
  logic               found [MAX_KEEP+1];
  cell_ctrl_t         ctrl  [MAX_KEEP];

  assign accept   = start_i & ~busy_o;
  assign do_offer = accept & (item_i.operation == OP_OFFER);
  assign do_flush = accept & (item_i.operation == OP_FLUSH);
  assign busy_o   = (state_q == ST_FLUSH);

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_sel)
      REG_KEEP_COUNT: prdata = APB_DW'(keep_q);
      REG_MAG_RANK:   prdata = APB_DW'(abs_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
      abs_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KEEP_COUNT: keep_q <= pwdata[KEEP_W-1:0];
        REG_MAG_RANK:   abs_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (keep_q == '0) begin
      limit = CNT_W'(1);
    end else if (32'(keep_q) > 32'(MAX_KEEP)) begin
      limit = CNT_W'(MAX_KEEP);
    end else begin
      limit = CNT_W'(keep_q);
    end
    fill_inc = {1'b0, fill_q} + (CNT_W+1)'(1);
    if (fill_inc > {1'b0, limit}) begin
      newfill = limit;
    end else begin
      newfill = fill_inc[CNT_W-1:0];
    end
  end

  assign new_key   = key_of(item_i.elem_value, abs_q);
  assign new_entry = '{row: item_i.elem_row, col: item_i.elem_col, value: item_i.elem_value};

  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    if (i == 0) begin : g_head
      assign left_ent = '0;
    end else begin : g_body
      assign left_ent = ent[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    assign ctrl[i] = '{insert:    do_offer,
                       shift_out: busy_o,
                       active:    (CNT_W+1)'(i) < {1'b0, fill_q},
                       write:     (CNT_W+1)'(i) < {1'b0, newfill},
                       mag_rank:  abs_q};

    tket_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .new_entry_i (new_entry),
      .new_key_i   (new_key),
      .left_i      (left_ent),
      .right_i     (right_ent),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .entry_o     (ent[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    result_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (do_offer) begin
          fill_d = newfill;
        end else if (do_flush) begin
          fill_d = '0;
          if (fill_q == '0) begin
            strobe_d          = 1'b1;
            result_d.out_last = 1'b1;
          end else begin
            cnt_d   = fill_q;
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        strobe_d           = 1'b1;
        result_d.out_valid = 1'b1;
        result_d.out_row   = ent[0].row;
        result_d.out_col   = ent[0].col;
        result_d.out_value = ent[0].value;
        result_d.out_last  = (cnt_q == CNT_W'(1));
        cnt_d              = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(MAX_KEEP))
    else $error("list fill exceeds the cell count");

  a_flush_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> strobe_o && result_o.out_valid)
    else $error("flush cycle without a result beat");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.out_valid |-> result_o.out_last)
    else $error("empty-list beat without last marker");

  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_flush && fill_q == '0 |=> strobe_o && !result_o.out_valid && !busy_o)
    else $error("empty flush did not give a single beat");

  a_no_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !do_flush |=> !strobe_o)
    else $error("result beat without a flush");

endmodule
